@@ rtl/drmm_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual-ring message mailbox package
// Shared widths, codes, state type and control structs for the mailbox.
// ----------------------------------------------------------------------------
package drmm_pkg;

  localparam int DATA_W          = 32;
  localparam int WORDS_PER_MSG   = 8;
  localparam int WORD_IDX_W      = $clog2(WORDS_PER_MSG);
  localparam int MSG_W           = DATA_W * WORDS_PER_MSG;
  localparam int CNT_W           = 5;
  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    OP_PUSH_REQ = 2'd0,
    OP_TAKE_REQ = 2'd1,
    OP_PUT_RSP  = 2'd2,
    OP_TAKE_RSP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    RING_REQ = 1'b0,
    RING_RSP = 1'b1
  } ring_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_e;

  // Query and advance command from the sequencer to the pointer block.
  typedef struct packed {
    logic  adv;
    ring_e ring;
    logic  pop;
  } ptr_req_t;

  // Answer of the pointer block for the ring and direction in the query.
  typedef struct packed {
    logic ready;
    logic ok;
  } ptr_rsp_t;

  function automatic int slot_width(input int max_entries);
    return (max_entries > 1) ? $clog2(max_entries) : 1;
  endfunction

endpackage

@@ rtl/drmm_ptrs.sv @@
// ----------------------------------------------------------------------------
// Mailbox ring pointers
// Entry count register, wrap-bit pointers of both rings, fullness checks and
// the remainder sequence that rebases the pointers after an entry count write.
// ----------------------------------------------------------------------------
module drmm_ptrs import drmm_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int SLOT_W      = slot_width(MAX_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  ptr_req_t          req,
  output ptr_rsp_t          rsp,
  output logic [SLOT_W-1:0] slot
);

  localparam int PW  = $clog2(2 * MAX_ENTRIES);
  localparam int NW  = $clog2(MAX_ENTRIES + 1);
  localparam int MW  = NW + 1;
  localparam int SCW = (PW > 1) ? $clog2(PW) : 1;
  localparam int XW  = MW + PW;

  logic [CNT_W-1:0] count_r;
  logic [NW-1:0]    n;
  logic [MW-1:0]    m;

  // Raw pointers as last stored, and the same pointers reduced modulo 2n.
  logic [PW-1:0] wr_raw_r [2];
  logic [PW-1:0] rd_raw_r [2];
  logic [PW-1:0] wr_red_r [2];
  logic [PW-1:0] rd_red_r [2];
  logic [PW-1:0] wr_step  [2];
  logic [PW-1:0] rd_step  [2];

  logic           pend_r;
  logic           busy_r;
  logic [SCW-1:0] step_r;

  logic [PW-1:0] wr_sel, rd_sel, ptr_sel, ptr_next;
  logic [MW-1:0] occ, ptr_ext, ptr_inc;
  logic          full, empty;
  logic [XW-1:0] divisor;

  always_comb begin
    if (count_r == '0) begin
      n = NW'(1);
    end else if (int'(count_r) > MAX_ENTRIES) begin
      n = NW'(MAX_ENTRIES);
    end else begin
      n = NW'(count_r);
    end
    m = {n, 1'b0};
  end

  always_comb begin
    wr_sel  = wr_red_r[req.ring];
    rd_sel  = rd_red_r[req.ring];
    if (wr_sel >= rd_sel) begin
      occ = MW'(wr_sel) - MW'(rd_sel);
    end else begin
      occ = MW'(wr_sel) + m - MW'(rd_sel);
    end
    full    = (occ >= MW'(n));
    empty   = (occ == '0);
    ptr_sel = req.pop ? rd_sel : wr_sel;
    ptr_ext = MW'(ptr_sel);
    ptr_inc = ptr_ext + MW'(1);
    ptr_next = (ptr_inc == m) ? '0 : PW'(ptr_inc);
    if (ptr_ext >= MW'(n)) begin
      slot = SLOT_W'(ptr_ext - MW'(n));
    end else begin
      slot = SLOT_W'(ptr_ext);
    end
    rsp.ready = !pend_r && !busy_r;
    rsp.ok    = req.pop ? !empty : !full;
  end

  // One restoring remainder step per cycle on all four pointers.
  always_comb begin
    divisor = XW'(m) << step_r;
    for (int i = 0; i < 2; i++) begin
      wr_step[i] = (XW'(wr_red_r[i]) >= divisor) ?
                   PW'(XW'(wr_red_r[i]) - divisor) : wr_red_r[i];
      rd_step[i] = (XW'(rd_red_r[i]) >= divisor) ?
                   PW'(XW'(rd_red_r[i]) - divisor) : rd_red_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ENTRY_COUNT_RESET;
      pend_r  <= 1'b0;
      busy_r  <= 1'b0;
      step_r  <= '0;
      for (int i = 0; i < 2; i++) begin
        wr_raw_r[i] <= '0;
        rd_raw_r[i] <= '0;
        wr_red_r[i] <= '0;
        rd_red_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
        pend_r  <= 1'b1;
      end else if (pend_r) begin
        pend_r <= 1'b0;
      end

      if (pend_r) begin
        busy_r <= 1'b1;
        step_r <= SCW'(PW - 1);
        for (int i = 0; i < 2; i++) begin
          wr_red_r[i] <= wr_raw_r[i];
          rd_red_r[i] <= rd_raw_r[i];
        end
      end else if (busy_r) begin
        for (int i = 0; i < 2; i++) begin
          wr_red_r[i] <= wr_step[i];
          rd_red_r[i] <= rd_step[i];
        end
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - SCW'(1);
        end
      end else if (req.adv) begin
        if (req.pop) begin
          rd_raw_r[req.ring] <= ptr_next;
          rd_red_r[req.ring] <= ptr_next;
        end else begin
          wr_raw_r[req.ring] <= ptr_next;
          wr_red_r[req.ring] <= ptr_next;
        end
      end
    end
  end

endmodule

@@ rtl/dual_ring_message_mailbox.sv @@
// ----------------------------------------------------------------------------
// Dual-ring message mailbox
// Request and response rings of eight-word messages held in one word-wide
// memory, with wrap-bit pointers and full and empty refusal.
// ----------------------------------------------------------------------------
// An accepted push moves its message through S_WRITE and S_DONE, a pop through
// S_READ, S_DRAIN and S_DONE, and a refused transaction goes straight to S_DONE;
// the result waits in a register. The single memory port moves the eight words
// of a message one word per cycle, and no new transaction is accepted until the
// last one has loaded its result. After an entry count write no input is
// accepted while the pointers are rebased. Reset clears the pointers and sets
// the entry count to 16; message memory contents are undefined until written.
module dual_ring_message_mailbox import drmm_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // Configuration: entry_count.
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  // Input transaction channel.
  input  logic             in_tvalid,
  output logic             in_tready,
  // Fields from bit 0 up: in_header, in_payload_1 .. in_payload_7.
  input  logic [MSG_W-1:0] in_tdata,
  // Fields from bit 0 up: operation.
  input  logic [1:0]       in_tuser,
  // Result transaction channel.
  output logic             out_tvalid,
  input  logic             out_tready,
  // Fields from bit 0 up: out_header, out_payload_1 .. out_payload_7.
  output logic [MSG_W-1:0] out_tdata,
  // Fields from bit 0 up: status.
  output logic [1:0]       out_tuser
);

  localparam int SLOT_W   = slot_width(MAX_ENTRIES);
  localparam int MEM_DEPTH = 2 * MAX_ENTRIES * WORDS_PER_MSG;
  localparam int AW       = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] RSP_BASE = AW'(MAX_ENTRIES * WORDS_PER_MSG);

  // Both rings share one memory; the response ring sits in the upper half.
  logic [DATA_W-1:0] mem [MEM_DEPTH];

  state_e state_r, state_nxt;

  op_e      op;
  ptr_req_t preq;
  ptr_rsp_t prsp;
  logic [SLOT_W-1:0] slot;

  logic in_acc;
  logic out_free;
  logic mem_we, mem_re, cnt_en, load_out;

  logic [WORD_IDX_W-1:0] cnt_r;
  logic [AW-1:0]         base_r, base_nxt;
  logic [AW-1:0]         addr;
  logic [DATA_W-1:0]     buf_r [WORDS_PER_MSG];
  logic [DATA_W-1:0]     rd_data_r;
  logic                  rd_vld_r;
  status_e               status_r;

  logic [MSG_W-1:0] out_data_r;
  status_e          out_status_r;
  logic             out_tvalid_r;

  // Decode the operation into a ring and a direction for the pointer block.
  always_comb begin
    op        = op_e'(in_tuser);
    preq.ring = (op == OP_PUT_RSP || op == OP_TAKE_RSP) ? RING_RSP : RING_REQ;
    preq.pop  = (op == OP_TAKE_REQ || op == OP_TAKE_RSP);
    in_acc    = in_tvalid && in_tready;
    preq.adv  = in_acc && prsp.ok;
    out_free  = !out_tvalid_r || out_tready;
  end

  drmm_ptrs #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SLOT_W      (SLOT_W)
  ) u_ptrs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (preq),
    .rsp         (prsp),
    .slot        (slot)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!prsp.ok) begin
            state_nxt = S_DONE;
          end else if (preq.pop) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (cnt_r == WORD_IDX_W'(WORDS_PER_MSG - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        if (cnt_r == WORD_IDX_W'(WORDS_PER_MSG - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    cnt_en    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = prsp.ready;
      end
      S_WRITE: begin
        mem_we = 1'b1;
        cnt_en = 1'b1;
      end
      S_READ: begin
        mem_re = 1'b1;
        cnt_en = 1'b1;
      end
      S_DRAIN: begin
        cnt_en = 1'b0;
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Word address of the first word of the message slot.
  always_comb begin
    base_nxt = AW'(slot) << WORD_IDX_W;
    if (preq.ring == RING_RSP) begin
      base_nxt = base_nxt + RSP_BASE;
    end
    addr = base_r + AW'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_re;
      if (cnt_en) begin
        cnt_r <= cnt_r + WORD_IDX_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Message buffer: loaded on accept, drained into memory word by word on a
  // push and refilled from memory on a pop. Shifting in zeros during a push
  // leaves it cleared, so a push reports zero words.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= base_nxt;
      if (prsp.ok) begin
        status_r <= ST_OK;
      end else if (preq.pop) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_FULL;
      end
      for (int i = 0; i < WORDS_PER_MSG; i++) begin
        buf_r[i] <= (prsp.ok && !preq.pop) ? in_tdata[i*DATA_W +: DATA_W] : '0;
      end
    end else if (mem_we || rd_vld_r) begin
      for (int i = 0; i < WORDS_PER_MSG - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      buf_r[WORDS_PER_MSG-1] <= rd_vld_r ? rd_data_r : '0;
    end
    if (load_out) begin
      out_status_r <= status_r;
      for (int i = 0; i < WORDS_PER_MSG; i++) begin
        out_data_r[i*DATA_W +: DATA_W] <= buf_r[i];
      end
    end
  end

  // Message memory: one write or one read per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= buf_r[0];
    end
    if (mem_re) begin
      rd_data_r <= mem[addr];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  // No transaction may be taken while the pointers are being rebased.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> prsp.ready)
    else $error("input accepted while pointer rebase in progress");

  // Read data only returns during a pop.
  a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_READ || state_r == S_DRAIN))
    else $error("memory read data outside of a pop");

  // A presented result never carries the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_status_r == ST_OK || out_status_r == ST_FULL ||
                      out_status_r == ST_EMPTY))
    else $error("invalid status on result");

  // Loading the result register ends the transaction.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (state_r == S_IDLE && out_tvalid_r))
    else $error("result load did not return to idle");
`endif

endmodule
